// ===== rtl/rmi_pkg.sv =====
// rmi_pkg: types, constants and the microcode table of the rotation matrix integrator.
// Used by rotation_matrix_integrator; depends on nothing else.

package rmi_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int WORD_W        = 32;
    localparam int ANGLE_W       = 16;
    localparam int IN_DATA_W     = 48;   // yaw, pitch, roll
    localparam int OUT_DATA_W    = 320;  // nine elements and the error word
    localparam int PC_W          = 6;

    // operation flag carried in tuser
    localparam logic OP_ROTATE    = 1'b0;
    localparam logic OP_NORMALIZE = 1'b1;

    localparam logic [PC_W-1:0] NORM_ENTRY = PC_W'(16);
    localparam logic [PC_W-1:0] LAST_PC    = PC_W'(47);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // operand sources for the shared multiplier
    typedef enum logic [4:0] {
        SRC_M0, SRC_M1, SRC_M2, SRC_M3, SRC_M4, SRC_M5, SRC_M6, SRC_M7, SRC_M8,
        SRC_T0, SRC_T1, SRC_T2,
        SRC_YAW, SRC_PITCH, SRC_ROLL,
        SRC_H, SRC_K
    } t_src;

    typedef enum logic [2:0] {
        ACC_KEEP,
        ACC_LD,
        ACC_ADD,
        ACC_SUB,
        ACC_NLD
    } t_acc_op;

    // write-back of the registered accumulator, shifted down by FRAC_BITS
    typedef enum logic [1:0] {
        WB_NONE,
        WB_ADD,
        WB_SET
    } t_wb_op;

    typedef enum logic [1:0] {
        SP_NONE,
        SP_DH,   // d from accumulator: error = d, h = half of -d
        SP_SK    // s from accumulator: error += s, k = 1.5 - s/2
    } t_sp;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_NORM,  // to NORM_ENTRY when the item is a normalize
        JMP_DONE
    } t_jmp;

    typedef struct packed {
        t_src        a_sel;
        t_src        b_sel;
        t_acc_op     acc_op;
        t_wb_op      wb_op;
        logic [3:0]  wb_dst;
        t_sp         sp;
        logic        copy_en;
        logic        copy_row;
        t_jmp        jmp;
    } t_uop;

    function automatic t_uop mk(t_src a, t_src b, t_acc_op acc, t_wb_op wb,
                                logic [3:0] dst, t_sp sp, logic cpy, logic row,
                                t_jmp jmp);
        t_uop u;
        u.a_sel    = a;
        u.b_sel    = b;
        u.acc_op   = acc;
        u.wb_op    = wb;
        u.wb_dst   = dst;
        u.sp       = sp;
        u.copy_en  = cpy;
        u.copy_row = row;
        u.jmp      = jmp;
        return u;
    endfunction

    // Rotate program at 0..15, normalize program at 16..47. A write-back
    // always uses the accumulator left by the previous step.
    function automatic t_uop ucode(logic [PC_W-1:0] pc);
        t_uop u;
        u = mk(SRC_M0, SRC_M0, ACC_KEEP, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
        unique case (pc)
            // rotate, row 0
            6'd0:  u = mk(SRC_M0, SRC_M0, ACC_KEEP, WB_NONE, 4'd0, SP_NONE, 1'b1, 1'b0, JMP_NORM);
            6'd1:  u = mk(SRC_T1, SRC_ROLL,  ACC_LD,  WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd2:  u = mk(SRC_T2, SRC_YAW,   ACC_SUB, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd3:  u = mk(SRC_T0, SRC_ROLL,  ACC_NLD, WB_ADD,  4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd4:  u = mk(SRC_T2, SRC_PITCH, ACC_SUB, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd5:  u = mk(SRC_T0, SRC_YAW,   ACC_LD,  WB_ADD,  4'd1, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd6:  u = mk(SRC_T1, SRC_PITCH, ACC_ADD, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            // rotate, row 1
            6'd7:  u = mk(SRC_M0, SRC_M0, ACC_KEEP, WB_ADD, 4'd2, SP_NONE, 1'b1, 1'b1, JMP_NEXT);
            6'd8:  u = mk(SRC_T1, SRC_ROLL,  ACC_LD,  WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd9:  u = mk(SRC_T2, SRC_YAW,   ACC_SUB, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd10: u = mk(SRC_T0, SRC_ROLL,  ACC_NLD, WB_ADD,  4'd3, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd11: u = mk(SRC_T2, SRC_PITCH, ACC_SUB, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd12: u = mk(SRC_T0, SRC_YAW,   ACC_LD,  WB_ADD,  4'd4, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd13: u = mk(SRC_T1, SRC_PITCH, ACC_ADD, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd14: u = mk(SRC_M0, SRC_M0, ACC_KEEP, WB_ADD, 4'd5, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd15: u = mk(SRC_M0, SRC_M0, ACC_KEEP, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_DONE);
            // normalize: dot product and half correction
            6'd16: u = mk(SRC_M0, SRC_M3, ACC_LD,  WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd17: u = mk(SRC_M1, SRC_M4, ACC_ADD, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd18: u = mk(SRC_M2, SRC_M5, ACC_ADD, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd19: u = mk(SRC_M0, SRC_M0, ACC_KEEP, WB_NONE, 4'd0, SP_DH, 1'b1, 1'b0, JMP_NEXT);
            6'd20: u = mk(SRC_M3, SRC_H, ACC_LD, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd21: u = mk(SRC_M4, SRC_H, ACC_LD, WB_ADD,  4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd22: u = mk(SRC_M5, SRC_H, ACC_LD, WB_ADD,  4'd1, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd23: u = mk(SRC_T0, SRC_H, ACC_LD, WB_ADD,  4'd2, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd24: u = mk(SRC_T1, SRC_H, ACC_LD, WB_ADD,  4'd3, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd25: u = mk(SRC_T2, SRC_H, ACC_LD, WB_ADD,  4'd4, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            // rescale row 0
            6'd26: u = mk(SRC_M0, SRC_M0, ACC_LD,  WB_ADD,  4'd5, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd27: u = mk(SRC_M1, SRC_M1, ACC_ADD, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd28: u = mk(SRC_M2, SRC_M2, ACC_ADD, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd29: u = mk(SRC_M0, SRC_M0, ACC_KEEP, WB_NONE, 4'd0, SP_SK, 1'b0, 1'b0, JMP_NEXT);
            6'd30: u = mk(SRC_M0, SRC_K, ACC_LD, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd31: u = mk(SRC_M1, SRC_K, ACC_LD, WB_SET,  4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd32: u = mk(SRC_M2, SRC_K, ACC_LD, WB_SET,  4'd1, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            // rescale row 1
            6'd33: u = mk(SRC_M3, SRC_M3, ACC_LD,  WB_SET,  4'd2, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd34: u = mk(SRC_M4, SRC_M4, ACC_ADD, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd35: u = mk(SRC_M5, SRC_M5, ACC_ADD, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd36: u = mk(SRC_M0, SRC_M0, ACC_KEEP, WB_NONE, 4'd0, SP_SK, 1'b0, 1'b0, JMP_NEXT);
            6'd37: u = mk(SRC_M3, SRC_K, ACC_LD, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd38: u = mk(SRC_M4, SRC_K, ACC_LD, WB_SET,  4'd3, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd39: u = mk(SRC_M5, SRC_K, ACC_LD, WB_SET,  4'd4, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            // row 2 = row 0 x row 1
            6'd40: u = mk(SRC_M0, SRC_M4, ACC_LD,  WB_SET,  4'd5, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd41: u = mk(SRC_M1, SRC_M3, ACC_SUB, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd42: u = mk(SRC_M1, SRC_M5, ACC_LD,  WB_SET,  4'd8, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd43: u = mk(SRC_M2, SRC_M4, ACC_SUB, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd44: u = mk(SRC_M2, SRC_M3, ACC_LD,  WB_SET,  4'd6, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd45: u = mk(SRC_M0, SRC_M5, ACC_SUB, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd46: u = mk(SRC_M0, SRC_M0, ACC_KEEP, WB_SET, 4'd7, SP_NONE, 1'b0, 1'b0, JMP_NEXT);
            6'd47: u = mk(SRC_M0, SRC_M0, ACC_KEEP, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0, JMP_DONE);
            default: u = mk(SRC_M0, SRC_M0, ACC_KEEP, WB_NONE, 4'd0, SP_NONE, 1'b0, 1'b0,
                            JMP_DONE);
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/rotation_matrix_integrator.sv =====
// rotation_matrix_integrator: 3x3 fixed-point rotation matrix, rotate and orthonormalize.
// Microcoded sequencer over one shared 32x32 multiply-accumulate; uses rmi_pkg.
//
//   channel   dir  signals                          payload
//   s (in)    in   i_s_tvalid o_s_tready            tdata[47:0] yaw|pitch|roll, tuser operation
//   m (out)   out  o_m_tvalid i_m_tready            tdata[319:0] m00..m22, norm_error
//
// Rotate item: a dispatch step, then the rotate microcode steps, before the result is loaded.
// Normalize item: the dispatch step, then the normalize steps; one multiply per step, shared MAC.
// One item at a time; the next input is taken once the result sits in the output register.
// A result not yet taken holds the sequencer on its final step until the output frees up.
// Reset (i_rst_n low, synchronous) sets the matrix to identity and the error word to zero.

module rotation_matrix_integrator #(
    parameter int FRAC_BITS = rmi_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [15:0] yaw_step, [31:16] pitch_step, [47:32] roll_step
    input  logic [rmi_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [0] operation
    input  logic [0:0]                       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, [319:288] norm_error
    output logic [rmi_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    localparam int W = rmi_pkg::WORD_W;
    localparam logic signed [W-1:0] ONE_LIM      = W'((1 << FRAC_BITS) - 1);
    localparam logic signed [W-1:0] THREE_HALVES = W'(3 << (FRAC_BITS - 1));

    rmi_pkg::t_state              r_state, n_state;
    logic [rmi_pkg::PC_W-1:0]     r_pc, n_pc;
    logic                         r_op;
    logic [W-1:0]                 r_m [9];
    logic [W-1:0]                 r_t [3];
    logic [W-1:0]                 r_err;
    logic [W-1:0]                 r_acc, n_acc;
    logic [W-1:0]                 r_h;
    logic [W-1:0]                 r_k;
    logic [W-1:0]                 r_yaw, r_pitch, r_roll;
    logic                         r_m_tvalid;
    logic [rmi_pkg::OUT_DATA_W-1:0] r_m_tdata;

    rmi_pkg::t_uop                uop;
    logic [W-1:0]                 opa, opb, prod;
    logic [W-1:0]                 acc_sh;
    logic [W-1:0]                 neg_d;
    logic                         s_xfer, running, out_free, out_load;

    function automatic logic [W-1:0] clamp(logic [rmi_pkg::ANGLE_W-1:0] raw);
        logic signed [W-1:0] s;
        s = W'($signed(raw));
        if (s > ONE_LIM) begin
            s = ONE_LIM;
        end else if (s < -ONE_LIM) begin
            s = -ONE_LIM;
        end
        return s;
    endfunction

    assign o_s_tready = (r_state == rmi_pkg::ST_IDLE) && i_rst_n;
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign running    = (r_state == rmi_pkg::ST_RUN);
    assign out_free   = !r_m_tvalid || i_m_tready;
    assign uop        = rmi_pkg::ucode(r_pc);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmi_pkg::ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        out_load = 1'b0;
        unique case (r_state)
            rmi_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    n_state = rmi_pkg::ST_RUN;
                    n_pc    = '0;
                end
            end
            rmi_pkg::ST_RUN: begin
                unique case (uop.jmp)
                    rmi_pkg::JMP_NEXT: n_pc = r_pc + 1'b1;
                    rmi_pkg::JMP_NORM: n_pc = (r_op == rmi_pkg::OP_NORMALIZE) ?
                                              rmi_pkg::NORM_ENTRY : r_pc + 1'b1;
                    rmi_pkg::JMP_DONE: begin
                        if (out_free) begin
                            out_load = 1'b1;
                            n_state  = rmi_pkg::ST_IDLE;
                        end
                    end
                    default: n_pc = r_pc;
                endcase
            end
            default: n_state = rmi_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    always_comb begin
        unique case (uop.a_sel)
            rmi_pkg::SRC_M0:    opa = r_m[0];
            rmi_pkg::SRC_M1:    opa = r_m[1];
            rmi_pkg::SRC_M2:    opa = r_m[2];
            rmi_pkg::SRC_M3:    opa = r_m[3];
            rmi_pkg::SRC_M4:    opa = r_m[4];
            rmi_pkg::SRC_M5:    opa = r_m[5];
            rmi_pkg::SRC_M6:    opa = r_m[6];
            rmi_pkg::SRC_M7:    opa = r_m[7];
            rmi_pkg::SRC_M8:    opa = r_m[8];
            rmi_pkg::SRC_T0:    opa = r_t[0];
            rmi_pkg::SRC_T1:    opa = r_t[1];
            rmi_pkg::SRC_T2:    opa = r_t[2];
            rmi_pkg::SRC_YAW:   opa = r_yaw;
            rmi_pkg::SRC_PITCH: opa = r_pitch;
            rmi_pkg::SRC_ROLL:  opa = r_roll;
            rmi_pkg::SRC_H:     opa = r_h;
            rmi_pkg::SRC_K:     opa = r_k;
            default:            opa = '0;
        endcase
    end

    always_comb begin
        unique case (uop.b_sel)
            rmi_pkg::SRC_M0:    opb = r_m[0];
            rmi_pkg::SRC_M1:    opb = r_m[1];
            rmi_pkg::SRC_M2:    opb = r_m[2];
            rmi_pkg::SRC_M3:    opb = r_m[3];
            rmi_pkg::SRC_M4:    opb = r_m[4];
            rmi_pkg::SRC_M5:    opb = r_m[5];
            rmi_pkg::SRC_M6:    opb = r_m[6];
            rmi_pkg::SRC_M7:    opb = r_m[7];
            rmi_pkg::SRC_M8:    opb = r_m[8];
            rmi_pkg::SRC_T0:    opb = r_t[0];
            rmi_pkg::SRC_T1:    opb = r_t[1];
            rmi_pkg::SRC_T2:    opb = r_t[2];
            rmi_pkg::SRC_YAW:   opb = r_yaw;
            rmi_pkg::SRC_PITCH: opb = r_pitch;
            rmi_pkg::SRC_ROLL:  opb = r_roll;
            rmi_pkg::SRC_H:     opb = r_h;
            rmi_pkg::SRC_K:     opb = r_k;
            default:            opb = '0;
        endcase
    end

    // low word of the product is the same for signed and unsigned operands
    assign prod   = opa * opb;
    assign acc_sh = W'($signed(r_acc) >>> FRAC_BITS);
    assign neg_d  = '0 - acc_sh;

    always_comb begin
        unique case (uop.acc_op)
            rmi_pkg::ACC_KEEP: n_acc = r_acc;
            rmi_pkg::ACC_LD:   n_acc = prod;
            rmi_pkg::ACC_ADD:  n_acc = r_acc + prod;
            rmi_pkg::ACC_SUB:  n_acc = r_acc - prod;
            rmi_pkg::ACC_NLD:  n_acc = '0 - prod;
            default:           n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // identity: diagonal elements sit at 0, 4 and 8
            for (int i = 0; i < 9; i++) begin
                r_m[i] <= (i == 0 || i == 4 || i == 8) ? ONE_LIM : '0;
            end
            r_err  <= '0;
        end else if (running) begin
            unique case (uop.wb_op)
                rmi_pkg::WB_ADD: r_m[uop.wb_dst] <= r_m[uop.wb_dst] + acc_sh;
                rmi_pkg::WB_SET: r_m[uop.wb_dst] <= acc_sh;
                rmi_pkg::WB_NONE: ;
                default: ;
            endcase
            unique case (uop.sp)
                rmi_pkg::SP_DH:   r_err <= acc_sh;
                rmi_pkg::SP_SK:   r_err <= r_err + acc_sh;
                rmi_pkg::SP_NONE: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_op    <= i_s_tuser[0];
            r_yaw   <= clamp(i_s_tdata[15:0]);
            r_pitch <= clamp(i_s_tdata[31:16]);
            r_roll  <= clamp(i_s_tdata[47:32]);
        end
        if (running) begin
            r_acc <= n_acc;
            if (uop.copy_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_t[i] <= uop.copy_row ? r_m[3 + i] : r_m[i];
                end
            end
            // halving truncates toward zero: add the sign bit before the shift
            if (uop.sp == rmi_pkg::SP_DH) begin
                r_h <= W'($signed(neg_d + W'(neg_d[W-1])) >>> 1);
            end
            if (uop.sp == rmi_pkg::SP_SK) begin
                r_k <= THREE_HALVES - W'($signed(acc_sh + W'(acc_sh[W-1])) >>> 1);
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_tdata <= {r_err, r_m[8], r_m[7], r_m[6], r_m[5], r_m[4],
                          r_m[3], r_m[2], r_m[1], r_m[0]};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // ---------------- assertions ----------------
    a_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> (r_state == rmi_pkg::ST_RUN) && (r_pc == '0))
        else $error("sequencer did not start at step zero after an input transfer");

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        running |-> (r_pc <= rmi_pkg::LAST_PC))
        else $error("step counter ran past the microcode program");

    a_rotate_keeps_row2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (running && (r_op == rmi_pkg::OP_ROTATE)) |=>
            ($stable(r_m[6]) && $stable(r_m[7]) && $stable(r_m[8])))
        else $error("rotate item modified row 2");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result loaded over an untaken result");

    a_load_matches_matrix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_m_tdata[W-1:0] == $past(r_m[0])) && o_m_tvalid)
        else $error("result register does not hold the finished matrix");

endmodule
